### design/nmea_pkg.sv
package nmea_pkg;

  // Field count width and default field cap
  localparam int FieldCountW = 7;
  localparam int DefaultMaxFields = 64;

  // Characters of interest
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChNul    = 8'h00;

  // Input item kinds
  localparam logic KindData = 1'b0;
  localparam logic KindEol  = 1'b1;

  // line_status codes
  localparam logic [1:0] StatusEmpty    = 2'd0;
  localparam logic [1:0] StatusOther    = 2'd1;
  localparam logic [1:0] StatusSentence = 2'd2;

  // checksum_state codes
  localparam logic [1:0] CksNone     = 2'd0;
  localparam logic [1:0] CksMatch    = 2'd1;
  localparam logic [1:0] CksMismatch = 2'd2;

  // sentence_kind codes
  localparam logic [2:0] SentNone = 3'd0;
  localparam int NumNames = 4;
  localparam int NameLen  = 5;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]             line_status;
    logic [1:0]             checksum_state;
    logic [2:0]             sentence_kind;
    logic [FieldCountW-1:0] field_count;
    logic [7:0]             computed_sum;
    logic [7:0]             received_sum;
  } result_t;

  // Character at position pos of known sentence name idx
  function automatic logic [7:0] name_char(input logic [1:0] idx, input logic [2:0] pos);
    logic [8*NameLen-1:0] word;
    logic [7:0]           ch;
    case (idx)
      2'd0:    word = "GPGSA";
      2'd1:    word = "GPGGA";
      2'd2:    word = "GPRMC";
      default: word = "GPGSV";
    endcase
    case (pos)
      3'd0:    ch = word[39:32];
      3'd1:    ch = word[31:24];
      3'd2:    ch = word[23:16];
      3'd3:    ch = word[15:8];
      3'd4:    ch = word[7:0];
      default: ch = ChNul;
    endcase
    return ch;
  endfunction

  // Hex digit value, anything else reads as zero
  function automatic logic [3:0] hex_value(input logic [7:0] b);
    logic [3:0] v;
    if (b >= 8'h30 && b <= 8'h39) begin
      v = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      v = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      v = 4'(b - 8'h57);
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

endpackage

### design/nmea_sentence_checker.sv
// Checks NMEA 0183 text lines delivered one byte per transaction and closed by an
// end-of-line transaction. One byte is taken each unstalled cycle; data bytes give
// no result, and each end-of-line transaction produces one result in the output
// register on the following cycle, after which the line state is cleared for the
// next line. The per-byte state update is a single pass of short logic, so the
// block sustains one item per cycle; input is held off only while a finished
// result sits in the output register and is not being taken that same cycle.
module nmea_sentence_checker #(
  parameter int MAX_FIELDS = nmea_pkg::DefaultMaxFields
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  nmea_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output nmea_pkg::result_t result
);
  import nmea_pkg::*;

  localparam logic [FieldCountW-1:0] MaxF = FieldCountW'(MAX_FIELDS);

  // Line phases
  localparam logic [2:0] PhFirst    = 3'd0;
  localparam logic [2:0] PhBody     = 3'd1;
  localparam logic [2:0] PhHex1     = 3'd2;
  localparam logic [2:0] PhHex2     = 3'd3;
  localparam logic [2:0] PhStop     = 3'd4;
  localparam logic [2:0] PhStarDone = 3'd5;

  logic [2:0]             phase, phase_next;
  logic [7:0]             running_xor, running_xor_next;
  logic [FieldCountW-1:0] comma_counter, comma_counter_next;
  logic [2:0]             name_position, name_position_next;
  logic [NumNames-1:0]    name_candidates, name_candidates_next;
  logic [3:0]             hex_high, hex_high_next;
  logic [7:0]             star_sum, star_sum_next;
  logic [1:0]             line_class, line_class_next;

  logic    take;
  logic    take_eol;
  logic    starred;
  result_t res_next;

  assign item_ready = !result_valid || result_ready;
  assign take       = item_valid && item_ready;
  assign take_eol   = take && (item.kind == KindEol);

  // Per-byte line state update
  always_comb begin
    phase_next           = phase;
    running_xor_next     = running_xor;
    comma_counter_next   = comma_counter;
    name_position_next   = name_position;
    name_candidates_next = name_candidates;
    hex_high_next        = hex_high;
    star_sum_next        = star_sum;
    line_class_next      = line_class;
    if (take_eol) begin
      phase_next           = PhFirst;
      running_xor_next     = 8'd0;
      comma_counter_next   = '0;
      name_position_next   = 3'd0;
      name_candidates_next = '1;
      hex_high_next        = 4'd0;
      star_sum_next        = 8'd0;
      line_class_next      = StatusEmpty;
    end else if (take) begin
      unique case (phase)
        PhFirst: begin
          phase_next = (item.data_byte == ChDollar) ? PhBody : PhStop;
          if (item.data_byte == ChDollar) begin
            line_class_next = StatusSentence;
          end else if (item.data_byte == ChNul) begin
            line_class_next = StatusEmpty;
          end else begin
            line_class_next = StatusOther;
          end
        end
        PhBody: begin
          if (item.data_byte == ChNul) begin
            phase_next = PhStop;
          end else if (item.data_byte == ChStar) begin
            phase_next = PhHex1;
          end else begin
            running_xor_next = running_xor ^ item.data_byte;
            if (item.data_byte == ChComma) begin
              // a name shorter than five characters matches nothing
              if (comma_counter == '0 && name_position != 3'd5) begin
                name_candidates_next = '0;
              end
              comma_counter_next = comma_counter + 1'b1;
              if (comma_counter_next >= MaxF) begin
                phase_next = PhStop;
              end
            end else if (comma_counter == '0) begin
              if (name_position < 3'd5) begin
                for (int j = 0; j < NumNames; j++) begin
                  if (name_char(2'(j), name_position) != item.data_byte) begin
                    name_candidates_next[j] = 1'b0;
                  end
                end
              end else begin
                name_candidates_next = '0;
              end
              if (name_position != 3'd7) begin
                name_position_next = name_position + 3'd1;
              end
            end
          end
        end
        PhHex1: begin
          phase_next = (item.data_byte == ChNul) ? PhStarDone : PhHex2;
          if (item.data_byte == ChNul) begin
            star_sum_next = 8'd0;
          end else begin
            hex_high_next = hex_value(item.data_byte);
            star_sum_next = {hex_value(item.data_byte), 4'd0};
          end
        end
        PhHex2: begin
          if (item.data_byte != ChNul) begin
            star_sum_next = {hex_high, hex_value(item.data_byte)};
          end
          phase_next = PhStarDone;
        end
        default: begin
        end
      endcase
    end
  end

  // Result for the line closing now
  always_comb begin
    res_next = '0;
    starred  = (phase == PhHex1) || (phase == PhHex2) || (phase == PhStarDone);
    res_next.line_status = line_class;
    if (line_class == StatusSentence) begin
      if (starred) begin
        res_next.checksum_state = (running_xor == star_sum) ? CksMatch : CksMismatch;
      end
      // lowest live candidate wins
      if (comma_counter != '0 && res_next.checksum_state != CksMismatch) begin
        for (int j = NumNames - 1; j >= 0; j--) begin
          if (name_candidates[j]) begin
            res_next.sentence_kind = 3'(j + 1);
          end
        end
      end
      res_next.field_count  = comma_counter;
      res_next.computed_sum = running_xor;
      res_next.received_sum = starred ? star_sum : 8'd0;
    end
  end

  // Line state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PhFirst;
      running_xor     <= 8'd0;
      comma_counter   <= '0;
      name_position   <= 3'd0;
      name_candidates <= '1;
      hex_high        <= 4'd0;
      star_sum        <= 8'd0;
      line_class      <= StatusEmpty;
    end else begin
      phase           <= phase_next;
      running_xor     <= running_xor_next;
      comma_counter   <= comma_counter_next;
      name_position   <= name_position_next;
      name_candidates <= name_candidates_next;
      hex_high        <= hex_high_next;
      star_sum        <= star_sum_next;
      line_class      <= line_class_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take_eol) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_eol) begin
      result <= res_next;
    end
  end

  // Checks
  a_eol_clears: assert property (@(posedge clk) disable iff (rst)
    take_eol |=> phase == PhFirst && comma_counter == '0 && name_candidates == '1)
    else $error("line state not cleared after end of line");

  a_comma_cap: assert property (@(posedge clk) disable iff (rst)
    comma_counter <= MaxF)
    else $error("comma count beyond cap");

  a_not_sentence: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.line_status != StatusSentence |->
      result.checksum_state == CksNone && result.field_count == '0 &&
      result.sentence_kind == SentNone)
    else $error("non-sentence result carries sentence fields");

  a_match_sums: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.checksum_state == CksMatch |->
      result.computed_sum == result.received_sum)
    else $error("checksum match reported with differing sums");

  a_mismatch_kind: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.checksum_state == CksMismatch |->
      result.sentence_kind == SentNone)
    else $error("sentence kind given on checksum mismatch");

endmodule

### tb/nmea_sentence_checker_test.sv
module nmea_sentence_checker_test;
  timeunit 1ns;
  timeprecision 1ps;

  import nmea_pkg::*;

  localparam int FieldCap = DefaultMaxFields;
  localparam int ItemTarget = 1950;

  typedef logic [7:0] byte_q[$];

  // Where the checker stands within the current line
  typedef enum logic [2:0] {
    AwaitStart, InBody, StarHigh, StarLow, Halted, StarRead
  } line_phase_e;

  // How a generated sentence is closed off
  typedef enum int {
    StarGood, StarGoodLower, StarWrong, StarOneDigit, StarBare, StarJunk, StarAbsent
  } star_form_e;

  // Tracks each line as its bytes are accepted and holds the reports it must produce
  class sentence_report_board;
    result_t     pending_reports[$];
    int          errors;
    line_phase_e phase;
    logic [7:0]  xor_acc;
    logic [7:0]  star_val;
    logic [3:0]  star_hi;
    logic [6:0]  commas;
    logic [2:0]  word_pos;
    logic [3:0]  live_names;
    logic [1:0]  line_cls;
    logic [39:0] names[NumNames];

    function new();
      names[0] = "GPGSA";
      names[1] = "GPGGA";
      names[2] = "GPRMC";
      names[3] = "GPGSV";
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      phase = AwaitStart;
      xor_acc = '0;
      star_val = '0;
      star_hi = '0;
      commas = '0;
      word_pos = '0;
      live_names = '1;
      line_cls = StatusEmpty;
    endfunction

    function logic [3:0] digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return 4'(c - "0");
      if (c >= "A" && c <= "F") return 4'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 4'(c - "a" + 8'd10);
      return 4'd0;
    endfunction

    // Byte between the '$' and the '*'
    function void body_char(logic [7:0] b);
      int sh;
      if (b == ChNul) begin
        phase = Halted;
      end else if (b == ChStar) begin
        phase = StarHigh;
      end else begin
        xor_acc ^= b;
        if (b == ChComma) begin
          // the word must be exactly five letters to keep any name live
          if (commas == 0 && word_pos != 3'd5) live_names = '0;
          commas = commas + 7'd1;
          if (commas >= FieldCap) phase = Halted;
        end else if (commas == 0) begin
          if (word_pos < 3'd5) begin
            sh = 8 * (4 - int'(word_pos));
            for (int j = 0; j < NumNames; j++) begin
              if (names[j][sh +: 8] != b) live_names[j] = 1'b0;
            end
          end else begin
            live_names = '0;
          end
          if (word_pos < 3'd7) word_pos = word_pos + 3'd1;
        end
      end
    endfunction

    // Accepted input transaction
    function void note_byte(item_t t);
      logic [7:0] b;
      result_t    r;
      bit         starred;
      b = t.data_byte;
      if (t.kind == KindData) begin
        case (phase)
          AwaitStart: begin
            if (b == ChDollar) begin
              line_cls = StatusSentence;
              phase = InBody;
            end else if (b == ChNul) begin
              line_cls = StatusEmpty;
              phase = Halted;
            end else begin
              line_cls = StatusOther;
              phase = Halted;
            end
          end
          InBody: body_char(b);
          StarHigh: begin
            if (b == ChNul) begin
              star_val = '0;
              phase = StarRead;
            end else begin
              star_hi = digit_value(b);
              star_val = {star_hi, 4'h0};
              phase = StarLow;
            end
          end
          StarLow: begin
            if (b != ChNul) star_val = {star_hi, digit_value(b)};
            phase = StarRead;
          end
          default: ;
        endcase
      end else begin
        r = '0;
        r.line_status = line_cls;
        if (line_cls == StatusSentence) begin
          starred = (phase == StarHigh || phase == StarLow || phase == StarRead);
          if (starred) r.checksum_state = (xor_acc == star_val) ? CksMatch : CksMismatch;
          // lowest live name wins
          if (commas != 0 && r.checksum_state != CksMismatch) begin
            for (int j = NumNames - 1; j >= 0; j--) begin
              if (live_names[j]) r.sentence_kind = 3'(j + 1);
            end
          end
          r.field_count = commas;
          r.computed_sum = xor_acc;
          r.received_sum = starred ? star_val : 8'h00;
        end
        pending_reports.push_back(r);
        clear_line();
      end
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    // Accepted output transaction
    function void check_report(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        $error("report with no end of line outstanding");
        errors++;
        return;
      end
      want = pending_reports.pop_front();
      compare_field("line_status", 8'(want.line_status), 8'(got.line_status));
      compare_field("checksum_state", 8'(want.checksum_state), 8'(got.checksum_state));
      compare_field("sentence_kind", 8'(want.sentence_kind), 8'(got.sentence_kind));
      compare_field("field_count", 8'(want.field_count), 8'(got.field_count));
      compare_field("computed_sum", want.computed_sum, got.computed_sum);
      compare_field("received_sum", want.received_sum, got.received_sum);
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_ready;
  item_t   item;
  logic    result_valid;
  logic    result_ready;
  result_t result;

  bit                   calm;
  int                   bytes_sent;
  sentence_report_board board;
  string                sentence_names[NumNames] = '{"GPGSA", "GPGGA", "GPRMC", "GPGSV"};

  nmea_sentence_checker dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Mostly no gap or a short one, now and then a long one; none at all in calm stretches
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (lower ? 8'h57 : 8'h37) + 8'(n);
  endfunction

  // Printable byte that is neither a star nor a comma
  function automatic logic [7:0] filler_char();
    logic [7:0] b;
    do b = 8'($urandom_range(8'h7e, 8'h20));
    while (b == ChStar || b == ChComma);
    return b;
  endfunction

  // Non-zero byte that is not a hex digit
  function automatic logic [7:0] junk_char();
    logic [7:0] b;
    do b = 8'($urandom_range(255, 1));
    while ((b >= "0" && b <= "9") || (b >= "A" && b <= "F") || (b >= "a" && b <= "f"));
    return b;
  endfunction

  function automatic byte_q text_bytes(string s);
    byte_q q;
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    return q;
  endfunction

  // Append the star and checksum digits in the requested form
  function automatic void close_sentence(ref byte_q line, input star_form_e form);
    logic [7:0] sum;
    bit         lower;
    sum = '0;
    for (int i = 1; i < line.size(); i++) sum ^= line[i];
    lower = (form == StarGoodLower);
    if (form == StarWrong) sum ^= 8'($urandom_range(255, 1));
    if (form == StarAbsent) return;
    line.push_back(ChStar);
    case (form)
      StarBare: ;
      StarOneDigit: line.push_back(hex_char(sum[7:4], 1'($urandom_range(1))));
      StarJunk: begin
        line.push_back(junk_char());
        line.push_back(junk_char());
      end
      default: begin
        line.push_back(hex_char(sum[7:4], lower));
        line.push_back(hex_char(sum[3:0], lower));
      end
    endcase
  endfunction

  // One input transaction; valid stays high straight into the next one when there is no gap
  task automatic send_item(logic k, logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= '{kind: k, data_byte: b};
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_line(byte_q line);
    foreach (line[i]) send_item(KindData, line[i]);
    send_item(KindEol, 8'($urandom_range(255)));
  endtask

  task automatic send_sentence(string body, star_form_e form);
    byte_q line;
    line = text_bytes({"$", body});
    close_sentence(line, form);
    send_line(line);
  endtask

  // Mostly sentences with random content, some of them broken; the rest empty lines and noise
  task automatic send_random_line();
    byte_q      line;
    byte_q      word;
    int         pick;
    int         nfields;
    int         flen;
    star_form_e form;
    pick = $urandom_range(99);
    if (pick < 5) begin
      send_line(line);
      return;
    end
    if (pick < 20) begin
      repeat ($urandom_range(12, 1)) line.push_back(8'($urandom_range(255)));
      if ($urandom_range(2) == 0) line[0] = ChDollar;
      send_line(line);
      return;
    end
    word = text_bytes(sentence_names[$urandom_range(NumNames - 1)]);
    case ($urandom_range(9))
      6: word = word[0:$urandom_range(3)];
      7: word[$urandom_range(4)] = filler_char();
      8: word.push_back(filler_char());
      9: begin
        word.delete();
        repeat ($urandom_range(6)) word.push_back(filler_char());
      end
      default: ;
    endcase
    line.push_back(ChDollar);
    line = {line, word};
    nfields = ($urandom_range(99) < 3) ? $urandom_range(FieldCap + 3, FieldCap - 3)
                                       : $urandom_range(6);
    repeat (nfields) begin
      line.push_back(ChComma);
      flen = (nfields > 8) ? $urandom_range(1) : $urandom_range(4);
      repeat (flen) line.push_back(filler_char());
    end
    if (line.size() > 1 && $urandom_range(24) == 0)
      line[$urandom_range(line.size() - 1, 1)] = ChNul;
    pick = $urandom_range(99);
    form = (pick < 40) ? StarGood :
           (pick < 65) ? StarGoodLower :
           (pick < 77) ? StarWrong :
           (pick < 82) ? StarOneDigit :
           (pick < 86) ? StarBare :
           (pick < 92) ? StarJunk : StarAbsent;
    close_sentence(line, form);
    if ($urandom_range(6) == 0)
      repeat ($urandom_range(3, 1)) line.push_back(8'($urandom_range(255)));
    send_line(line);
  endtask

  // Stimulus
  initial begin
    byte_q line;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    calm = 1'b0;
    bytes_sent = 0;
    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty line, zero as first byte, line without a dollar
    send_line(line);
    send_line('{ChNul, ChDollar});
    send_line('{8'h41, 8'hff});
    // each known name, upper and lower case digits
    send_sentence("GPGSA,A,3", StarGood);
    send_sentence("GPGGA,1", StarGoodLower);
    send_sentence("GPRMC,,", StarWrong);
    send_sentence("GPGSV,1", StarAbsent);
    // words that only nearly match, and no comma at all
    send_sentence("GPGSAX,1", StarGood);
    send_sentence("GPGS,1", StarGood);
    send_sentence("GPGGA", StarGood);
    // missing and invalid hex digits
    send_sentence("GPRMC,1", StarOneDigit);
    send_sentence("GPRMC,1", StarBare);
    send_sentence("GPGGA,", StarJunk);
    send_line({text_bytes("$GPGGA,*"), ChNul, 8'h35});
    send_line({text_bytes("$GPGGA,*4"), ChNul, 8'h35});
    // zero byte inside the body
    send_line({text_bytes("$GP"), ChNul, text_bytes(",*00")});
    // bytes after the checksum are ignored
    line = text_bytes("$GPGSV,2");
    close_sentence(line, StarGood);
    send_line({line, text_bytes(",*9")});
    // field cap reached exactly, and overrun
    line = text_bytes("$GPGSA");
    repeat (FieldCap) line.push_back(ChComma);
    close_sentence(line, StarGood);
    send_line(line);
    line = text_bytes("$");
    repeat (FieldCap + 5) line.push_back(ChComma);
    close_sentence(line, StarJunk);
    send_line(line);

    while (bytes_sent < ItemTarget) begin
      if ($urandom_range(19) == 0) calm = !calm;
      send_random_line();
    end
    item_valid <= 1'b0;

    // drain outstanding reports, then allow the output stage to settle
    @(posedge clk);
    while (board.pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (board.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Output side back-pressure
  initial begin
    int stall;
    stall = 0;
    result_ready = 1'b0;
    do @(posedge clk);
    while (rst);
    forever begin
      if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        if (!calm && $urandom_range(99) < 25)
          stall = ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
      end
      @(posedge clk);
    end
  end

  // Transaction monitor
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready) board.note_byte(item);
      if (result_valid && result_ready) board.check_report(result);
    end
  end

  // Watchdog
  initial begin
    #4ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
